// ===== sv/lsq_pkg.sv =====
`timescale 1ns / 1ps

package lsq_pkg;

   // Field widths
   localparam int STAMP_W  = 48;
   localparam int TIME_W   = 40;
   localparam int LIMIT_W  = 31;
   localparam int COUNT_W  = 16;
   localparam int Q16_W    = 32;
   localparam int NOW_W    = 64;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = TIME_W;
   localparam int PROD_W   = STAMP_W + 10;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STABLE_TIME = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_TOL  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SAMPLES = 8'd3;

   // Reset values
   localparam logic [TIME_W-1:0]  STABLE_TIME_RST = 40'd1000000000;
   localparam logic [LIMIT_W-1:0] MAX_SPEED_RST   = 31'd32768;
   localparam logic [LIMIT_W-1:0] HEIGHT_TOL_RST  = 31'd6554;
   localparam logic [COUNT_W-1:0] MIN_SAMPLES_RST = 16'd3;

   localparam logic [COUNT_W-1:0] MIN_SAMPLES_FLOOR = 16'd2;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [TIME_W-1:0]  stable_time_ns;
      logic [LIMIT_W-1:0] speed_limit;
      logic [LIMIT_W-1:0] height_tol;
      logic [COUNT_W-1:0] min_samples;
   } cfg_type;

   // One classified observation waiting for the state unit
   typedef struct packed {
      logic               ok;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

endpackage

// ===== sv/lsq_front.sv =====
`timescale 1ns / 1ps

module lsq_front import lsq_pkg::*; (
   input  cfg_type                   cfg,
   input  logic signed [NOW_W-1:0]   now_ns,
   input  logic [STAMP_W-1:0]        land_timestamp_us,
   input  logic                      land_fresh,
   input  logic                      status_fresh,
   input  logic                      odom_fresh,
   input  logic                      landed_flag,
   input  logic                      values_finite,
   input  logic signed [Q16_W-1:0]   altitude,
   input  logic signed [Q16_W-1:0]   climb_rate,
   input  logic signed [Q16_W-1:0]   contact_height,
   output entry_type                 entry
);

   logic signed [Q16_W:0] speed_ext;
   logic signed [Q16_W:0] height_diff;
   logic [Q16_W:0]        speed_abs;
   logic [Q16_W:0]        height_abs;
   logic                  flags_ok;
   logic                  settings_ok;
   logic                  speed_ok;
   logic                  height_ok;

   // Form exact magnitudes at 33 bits
   always_comb begin
      speed_ext   = {climb_rate[Q16_W-1], climb_rate};
      height_diff = {altitude[Q16_W-1], altitude} - {contact_height[Q16_W-1], contact_height};
      speed_abs   = speed_ext[Q16_W] ? 33'(-speed_ext) : 33'(speed_ext);
      height_abs  = height_diff[Q16_W] ? 33'(-height_diff) : 33'(height_diff);
   end

   // Classify the observation
   always_comb begin
      flags_ok    = land_fresh & status_fresh & odom_fresh & landed_flag & values_finite;
      settings_ok = (cfg.stable_time_ns != '0) && (cfg.min_samples >= MIN_SAMPLES_FLOOR);
      speed_ok    = speed_abs <= {2'b00, cfg.speed_limit};
      height_ok   = height_abs <= {2'b00, cfg.height_tol};
      entry.ok    = !now_ns[NOW_W-1] && settings_ok && (land_timestamp_us != '0)
                    && flags_ok && speed_ok && height_ok;
      entry.stamp = land_timestamp_us;
   end

endmodule

// ===== sv/lsq_queue.sv =====
`timescale 1ns / 1ps

module lsq_queue import lsq_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  entry_type                      push_entry,
   input  logic                           pop,
   output entry_type                      head,
   output logic                           full,
   output logic                           not_empty,
   output logic [$clog2(DEPTH+1)-1:0]     count
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          slot_ff [DEPTH];
   logic [IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   // Advance pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the beat
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head      = slot_ff[rd_ptr_ff];
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule

// ===== sv/lsq_back.sv =====
`timescale 1ns / 1ps

module lsq_back import lsq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  entry_type  head,
   input  logic       not_empty,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_landed_stable
);

   logic [STAMP_W-1:0] first_ff, first_in;
   logic [STAMP_W-1:0] last_ff, last_in;
   logic [STAMP_W-1:0] span_ff, span_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               eval_in;

   logic               s1_valid_ff;
   logic               s1_eval_ff;
   logic [STAMP_W-1:0] s1_span_ff;
   logic [COUNT_W-1:0] s1_count_ff;

   logic               rsp_valid_ff;
   logic               rsp_stable_ff;

   logic               out_ready;
   logic               s1_ready;
   logic [PROD_W-1:0]  span_wide;
   logic [PROD_W-1:0]  span_ns;
   logic               stable;

   // Handshake between stages
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign pop       = not_empty && s1_ready;

   // Update the run for the popped beat
   always_comb begin
      first_in = first_ff;
      last_in  = last_ff;
      span_in  = span_ff;
      count_in = count_ff;
      eval_in  = 1'b0;
      if (!head.ok || ((last_ff != '0) && (head.stamp < last_ff))) begin
         first_in = '0;
         last_in  = '0;
         span_in  = '0;
         count_in = '0;
      end else if (head.stamp == last_ff) begin
         eval_in = 1'b1;
      end else if (first_ff == '0) begin
         first_in = head.stamp;
         last_in  = head.stamp;
         span_in  = '0;
         count_in = COUNT_W'(1);
      end else begin
         last_in  = head.stamp;
         span_in  = head.stamp - first_ff;
         count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
         eval_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff    <= '0;
         last_ff     <= '0;
         span_ff     <= '0;
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            first_ff <= first_in;
            last_ff  <= last_in;
            span_ff  <= span_in;
            count_ff <= count_in;
         end
         if (s1_ready) begin
            s1_valid_ff <= pop;
         end
      end
   end

   // Hold the snapshot for the compare stage
   always_ff @(posedge clock) begin
      if (pop) begin
         s1_eval_ff  <= eval_in;
         s1_span_ff  <= span_in;
         s1_count_ff <= count_in;
      end
   end

   // Span in ns: x1000 = x1024 - x16 - x8
   always_comb begin
      span_wide = PROD_W'(s1_span_ff);
      span_ns   = (span_wide << 10) - (span_wide << 4) - (span_wide << 3);
      stable    = s1_eval_ff && (s1_count_ff >= cfg.min_samples)
                  && (span_ns >= PROD_W'(cfg.stable_time_ns));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s1_valid_ff) begin
         rsp_stable_ff <= stable;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_landed_stable = rsp_stable_ff;

endmodule

// ===== sv/landing_stability_qualifier.sv =====
`timescale 1ns / 1ps

// Landing stability qualifier: takes one observation per cycle unless req_stall is
// high, and returns one landed_stable beat for each, in order. An accepted beat is
// checked against the limits in the front end, parked in a QUEUE_DEPTH-entry queue,
// then applied to the run state (first and last stamp, sample count) by an update
// loop that sets the sustained rate of one beat per cycle while rsp_stall is low.
// Each beat passes the queue, state stage and output register. The user must write
// registers through csr_ only while no beat is in flight; it is not enforced.
module landing_stability_qualifier import lsq_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      csr_wr_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [NOW_W-1:0]   req_now_ns,
   input  logic [STAMP_W-1:0]        req_land_timestamp_us,
   input  logic                      req_land_fresh,
   input  logic                      req_status_fresh,
   input  logic                      req_odom_fresh,
   input  logic                      req_landed_flag,
   input  logic                      req_values_finite,
   input  logic signed [Q16_W-1:0]   req_altitude,
   input  logic signed [Q16_W-1:0]   req_climb_rate,
   input  logic signed [Q16_W-1:0]   req_contact_height,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_landed_stable
);

   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   cfg_type             cfg_ff;
   entry_type           front_entry;
   entry_type           q_head;
   logic                q_push;
   logic                q_pop;
   logic                q_full;
   logic                q_not_empty;
   logic [QCNT_W-1:0]   q_count;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stable_time_ns <= STABLE_TIME_RST;
         cfg_ff.speed_limit    <= MAX_SPEED_RST;
         cfg_ff.height_tol     <= HEIGHT_TOL_RST;
         cfg_ff.min_samples    <= MIN_SAMPLES_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_STABLE_TIME: cfg_ff.stable_time_ns <= csr_wdata[TIME_W-1:0];
            CSR_MAX_SPEED:   cfg_ff.speed_limit    <= csr_wdata[LIMIT_W-1:0];
            CSR_HEIGHT_TOL:  cfg_ff.height_tol     <= csr_wdata[LIMIT_W-1:0];
            CSR_MIN_SAMPLES: cfg_ff.min_samples    <= csr_wdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   lsq_front u_front (
      .cfg               (cfg_ff),
      .now_ns            (req_now_ns),
      .land_timestamp_us (req_land_timestamp_us),
      .land_fresh        (req_land_fresh),
      .status_fresh      (req_status_fresh),
      .odom_fresh        (req_odom_fresh),
      .landed_flag       (req_landed_flag),
      .values_finite     (req_values_finite),
      .altitude          (req_altitude),
      .climb_rate        (req_climb_rate),
      .contact_height    (req_contact_height),
      .entry             (front_entry)
   );

   lsq_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (front_entry),
      .pop        (q_pop),
      .head       (q_head),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .count      (q_count)
   );

   lsq_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .head              (q_head),
      .not_empty         (q_not_empty),
      .pop               (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_landed_stable (rsp_landed_stable)
   );

   // Reset empties the output stage
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // Back end never pops an empty queue
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_count != '0)
      else $error("pop from empty queue");

   // A lone pop drains exactly one entry
   assert property (@(posedge clock) disable iff (reset)
      (q_pop && !q_push) |=> q_count == QCNT_W'($past(q_count) - 1'b1))
      else $error("queue count off after pop");

endmodule

// ===== test/tb_landing_stability_qualifier.sv =====
`timescale 1ns / 1ps

module tb_landing_stability_qualifier;
   import lsq_pkg::*;

   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 9;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 16;
   localparam int LONG_HOLD     = 300;
   localparam int QUIET_LIMIT   = 3000;
   localparam int RANDOM_ITEMS  = 1800;
   localparam int RANDOM_PHASES = 6;
   localparam int NS_PER_US     = 1000;

   localparam logic [4:0]         ALL_FLAGS = 5'b11111;
   localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
   localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;
   localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
   localparam longint Q_HI   = 64'sh0000_0000_7FFF_FFFF;
   localparam longint Q_LO   = -64'sh0000_0000_8000_0000;
   localparam longint NOW_HI = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint NOW_LO = 64'sh8000_0000_0000_0000;

   // One landing observation; flags are {land, status, odometry, landed, finite}
   typedef struct {
      logic signed [NOW_W-1:0] now_ns;
      logic [STAMP_W-1:0]      stamp;
      logic [4:0]              flags;
      logic signed [Q16_W-1:0] altitude;
      logic signed [Q16_W-1:0] climb_rate;
      logic signed [Q16_W-1:0] contact_height;
   } observation_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic signed [NOW_W-1:0] req_now_ns = '0;
   logic [STAMP_W-1:0]      req_land_timestamp_us = '0;
   logic                    req_land_fresh = 1'b0;
   logic                    req_status_fresh = 1'b0;
   logic                    req_odom_fresh = 1'b0;
   logic                    req_landed_flag = 1'b0;
   logic                    req_values_finite = 1'b0;
   logic signed [Q16_W-1:0] req_altitude = '0;
   logic signed [Q16_W-1:0] req_climb_rate = '0;
   logic signed [Q16_W-1:0] req_contact_height = '0;

   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_landed_stable;

   // Predictor copy of the settings and of the landing run
   cfg_type            cfg;
   logic [STAMP_W-1:0] run_first = '0;
   logic [STAMP_W-1:0] run_last = '0;
   logic [COUNT_W-1:0] run_count = '0;

   logic expected_stable[$];
   int   mismatches = 0;
   int   results_seen = 0;
   int   quiet_cycles = 0;
   bit   req_gaps_en = 1'b0;
   bit   stall_rsp_en = 1'b0;
   int   hold_rsp_cycles = 0;

   landing_stability_qualifier uut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_now_ns            (req_now_ns),
      .req_land_timestamp_us (req_land_timestamp_us),
      .req_land_fresh        (req_land_fresh),
      .req_status_fresh      (req_status_fresh),
      .req_odom_fresh        (req_odom_fresh),
      .req_landed_flag       (req_landed_flag),
      .req_values_finite     (req_values_finite),
      .req_altitude          (req_altitude),
      .req_climb_rate        (req_climb_rate),
      .req_contact_height    (req_contact_height),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_landed_stable     (rsp_landed_stable)
   );

   always #HALF_PERIOD clock = ~clock;

   // Stability test on the current run: enough samples and a long enough span
   function automatic logic run_is_stable();
      logic [63:0] span_ns;
      span_ns = 64'(run_last - run_first) * 64'(NS_PER_US);
      return run_count >= cfg.min_samples && span_ns >= 64'(cfg.stable_time_ns);
   endfunction

   // Apply one observation to the run state and return the expected landed_stable
   function automatic logic predict_stable(input observation_type o);
      logic signed [34:0] alt_x, ch_x, speed_abs, height_abs;
      logic               obs_ok;
      logic               stable;
      alt_x = o.altitude;
      ch_x = o.contact_height;
      speed_abs = o.climb_rate;
      if (speed_abs < 0) speed_abs = -speed_abs;
      height_abs = alt_x - ch_x;
      if (height_abs < 0) height_abs = -height_abs;
      obs_ok = !o.now_ns[NOW_W-1] && cfg.stable_time_ns != 0 &&
               cfg.min_samples >= MIN_SAMPLES_FLOOR && o.stamp != 0 && (&o.flags) &&
               speed_abs <= 35'(cfg.speed_limit) &&
               height_abs <= 35'(cfg.height_tol);
      stable = 1'b0;
      if (!obs_ok || (run_last != 0 && o.stamp < run_last)) begin
         // drop the run
         run_first = '0;
         run_last = '0;
         run_count = '0;
      end else if (o.stamp == run_last) begin
         stable = run_is_stable();
      end else if (run_first == 0) begin
         run_first = o.stamp;
         run_last = o.stamp;
         run_count = 1;
      end else begin
         // advance the run, count saturates
         run_last = o.stamp;
         if (run_count != COUNT_MAX) run_count = run_count + 1'b1;
         stable = run_is_stable();
      end
      return stable;
   endfunction

   function automatic observation_type make_obs(input longint now,
                                                input logic [STAMP_W-1:0] stamp,
                                                input logic [4:0] flags, input longint alt,
                                                input longint speed, input longint ch);
      observation_type o;
      o.now_ns = now;
      o.stamp = stamp;
      o.flags = flags;
      o.altitude = Q16_W'(alt);
      o.climb_rate = Q16_W'(speed);
      o.contact_height = Q16_W'(ch);
      return o;
   endfunction

   // Signed value within +-lim, often right at the limit
   function automatic longint signed_within(input logic [LIMIT_W-1:0] lim);
      longint mag;
      case ($urandom_range(0, 7))
         0, 1: mag = lim;
         2: mag = 0;
         default: mag = $urandom_range(0, lim);
      endcase
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   // Well-formed landed observation under the current limits
   function automatic observation_type landed_obs(input logic [STAMP_W-1:0] stamp);
      observation_type o;
      longint          ch, gap, alt;
      o.now_ns = {1'b0, 31'($urandom), 32'($urandom)};
      o.stamp = stamp;
      o.flags = ALL_FLAGS;
      o.climb_rate = Q16_W'(signed_within(cfg.speed_limit));
      gap = signed_within(cfg.height_tol);
      ch = longint'($signed(32'($urandom)));
      alt = ch + gap;
      if (alt > Q_HI || alt < Q_LO) alt = ch - gap;
      o.altitude = Q16_W'(alt);
      o.contact_height = Q16_W'(ch);
      return o;
   endfunction

   function automatic logic [LIMIT_W-1:0] random_limit();
      case ($urandom_range(0, 3))
         0: return LIMIT_MAX;
         1: return LIMIT_W'($urandom_range(0, 1000));
         default: return LIMIT_W'($urandom);
      endcase
   endfunction

   task automatic set_idling(input bit on);
      req_gaps_en = on;
      stall_rsp_en = on;
   endtask

   // Offer one beat, hold it until accepted, then log its expected result
   task automatic send_observation(input observation_type o);
      req_valid <= 1'b1;
      req_now_ns <= o.now_ns;
      req_land_timestamp_us <= o.stamp;
      {req_land_fresh, req_status_fresh, req_odom_fresh, req_landed_flag,
       req_values_finite} <= o.flags;
      req_altitude <= o.altitude;
      req_climb_rate <= o.climb_rate;
      req_contact_height <= o.contact_height;
      do @(posedge clock); while (req_stall !== 1'b0);
      expected_stable.push_back(predict_stable(o));
      if (req_gaps_en && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every expected beat is back
   task automatic drain_results(input int extra);
      req_valid <= 1'b0;
      while (expected_stable.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // Write all four registers (junk in unused upper bits), then an unmapped index
   task automatic write_settings(input cfg_type c);
      drain_results(SETTLE_CYCLES);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_STABLE_TIME;
      csr_wdata <= c.stable_time_ns;
      @(posedge clock);
      csr_index <= CSR_MAX_SPEED;
      csr_wdata <= {9'($urandom), c.speed_limit};
      @(posedge clock);
      csr_index <= CSR_HEIGHT_TOL;
      csr_wdata <= {9'($urandom), c.height_tol};
      @(posedge clock);
      csr_index <= CSR_MIN_SAMPLES;
      csr_wdata <= {24'($urandom), c.min_samples};
      @(posedge clock);
      csr_index <= CSR_IDX_W'(CSR_MIN_SAMPLES + 1 + $urandom_range(0, 251));
      csr_wdata <= {$urandom, 8'($urandom)};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg = c;
   endtask

   // Reset settings: limits hit exactly, repeats, backward stamps, every invalid cause of an observation
   task automatic test_reset_defaults();
      longint spd, tol;
      spd = MAX_SPEED_RST;
      tol = HEIGHT_TOL_RST;
      send_observation(make_obs(0, 100, ALL_FLAGS, tol, spd, 0));
      send_observation(make_obs(5, 100, ALL_FLAGS, 0, -spd, tol));
      send_observation(make_obs(7, 500100, ALL_FLAGS, 1, 0, 1));
      // span of one second in microseconds meets the default stable time
      send_observation(make_obs(NOW_HI, 1000100, ALL_FLAGS, 0, 0, 0));
      send_observation(make_obs(9, 1000100, ALL_FLAGS, 0, 0, 0));
      send_observation(make_obs(10, 1000099, ALL_FLAGS, 0, 0, 0));
      send_observation(make_obs(11, 2000, ALL_FLAGS, 0, 0, 0));
      send_observation(make_obs(12, 3000, ALL_FLAGS, 0, spd + 1, 0));
      for (int i = 0; i < 5; i++)
         send_observation(make_obs(13, 3000 + i, ALL_FLAGS & ~(5'b1 << i), 0, 0, 0));
      send_observation(make_obs(-1, 4000, ALL_FLAGS, 0, 0, 0));
      send_observation(make_obs(NOW_LO, 4001, ALL_FLAGS, 0, 0, 0));
      send_observation(make_obs(14, 0, ALL_FLAGS, 0, 0, 0));
      send_observation(make_obs(15, 4002, ALL_FLAGS, Q_HI, 0, Q_LO));
      send_observation(make_obs(16, 4003, ALL_FLAGS, Q_LO, 0, Q_HI));
      send_observation(make_obs(17, 4004, ALL_FLAGS, 0, Q_LO, 0));
      send_observation(make_obs(18, 4005, ALL_FLAGS, tol + 1, 0, 0));
      send_observation(make_obs(19, STAMP_MAX, ALL_FLAGS, 0, 0, 0));
   endtask

   // Register extremes: zero stable time, minimum below two, widest and zero limits
   task automatic test_register_extremes();
      write_settings(cfg_type'{40'd0, MAX_SPEED_RST, HEIGHT_TOL_RST, MIN_SAMPLES_RST});
      send_observation(make_obs(1, 10, ALL_FLAGS, 0, 0, 0));
      send_observation(make_obs(1, 20, ALL_FLAGS, 0, 0, 0));
      write_settings(cfg_type'{STABLE_TIME_RST, MAX_SPEED_RST, HEIGHT_TOL_RST, 16'd1});
      send_observation(make_obs(1, 30, ALL_FLAGS, 0, 0, 0));
      write_settings(cfg_type'{STABLE_TIME_RST, MAX_SPEED_RST, HEIGHT_TOL_RST, 16'd0});
      send_observation(make_obs(1, 40, ALL_FLAGS, 0, 0, 0));
      write_settings(cfg_type'{TIME_MAX, LIMIT_MAX, LIMIT_MAX, MIN_SAMPLES_FLOOR});
      send_observation(make_obs(0, 5, ALL_FLAGS, 0, Q_LO, 0));
      send_observation(make_obs(1, 1, ALL_FLAGS, Q_HI, Q_HI, 0));
      send_observation(make_obs(2, STAMP_MAX, ALL_FLAGS, 0, -Q_HI, -Q_HI));
      send_observation(make_obs(3, STAMP_MAX, ALL_FLAGS, 0, 0, Q_LO));
      write_settings(cfg_type'{40'd1, 31'd0, 31'd0, MIN_SAMPLES_FLOOR});
      send_observation(make_obs(1, 5, ALL_FLAGS, 7, 0, 7));
      send_observation(make_obs(1, 6, ALL_FLAGS, -3, 0, -3));
      send_observation(make_obs(1, 7, ALL_FLAGS, 0, 1, 0));
   endtask

   // Hold the result side off for a long stretch while beats keep coming
   task automatic test_backpressure();
      logic [STAMP_W-1:0] stamp;
      write_settings(cfg_type'{40'd5000, MAX_SPEED_RST, HEIGHT_TOL_RST, MIN_SAMPLES_RST});
      set_idling(1'b0);
      hold_rsp_cycles = LONG_HOLD;
      stamp = 10;
      for (int i = 0; i < 40; i++) begin
         if (i % 5 != 4) stamp = stamp + 2;
         send_observation(landed_obs(stamp));
      end
   endtask

   // Random phases: mostly landed runs with random content, some faults and noise
   task automatic test_random_runs();
      cfg_type            c;
      observation_type    o;
      logic [STAMP_W-1:0] stamp;
      int unsigned        step_max;
      longint             over, ch;
      int                 kind, sent, len, roll;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         kind = $urandom_range(0, 5);
         step_max = (kind == 0) ? 32'hFFFF_FFFF : $urandom_range(1, 5000);
         if (kind == 0) c.stable_time_ns = TIME_MAX;
         else if (kind == 1) c.stable_time_ns = 40'd1;
         else c.stable_time_ns = 40'(64'(step_max) * $urandom_range(100, 6000));
         c.speed_limit = random_limit();
         c.height_tol = random_limit();
         c.min_samples = ($urandom_range(0, 3) == 0) ? MIN_SAMPLES_FLOOR
                                                     : 16'($urandom_range(2, 8));
         write_settings(c);
         set_idling(phase % 3 != 2);
         sent = 0;
         while (sent < RANDOM_ITEMS / RANDOM_PHASES) begin
            if ($urandom_range(0, 6) == 0) begin
               // noise beat: every field random
               o.now_ns = {$urandom, $urandom};
               o.stamp = {16'($urandom), 32'($urandom)};
               o.flags = 5'($urandom);
               o.altitude = $urandom;
               o.climb_rate = $urandom;
               o.contact_height = $urandom;
               send_observation(o);
               sent++;
            end else begin
               stamp = ($urandom_range(0, 7) == 0) ? STAMP_MAX - 48'($urandom_range(0, step_max))
                                                   : 48'($urandom_range(1, 100000));
               len = $urandom_range(1, cfg.min_samples + 6);
               for (int k = 0; k < len; k++) begin
                  roll = $urandom_range(0, 19);
                  if (roll == 1) stamp = stamp - 48'($urandom_range(1, step_max));
                  else if (roll > 3) stamp = stamp + 48'($urandom_range(1, step_max));
                  o = landed_obs(stamp);
                  if (roll == 0) begin
                     // spoil one condition of an otherwise landed beat
                     case ($urandom_range(0, 4))
                        0: o.now_ns[NOW_W-1] = 1'b1;
                        1: o.stamp = '0;
                        2: o.flags[$urandom_range(0, 4)] = 1'b0;
                        3: begin
                           over = longint'(cfg.speed_limit) + 1;
                           o.climb_rate = Q16_W'($urandom_range(0, 1) ? -over : over);
                        end
                        default: begin
                           over = longint'(cfg.height_tol) + 1;
                           ch = Q_LO + longint'($urandom_range(0, 32'(Q_HI - over - Q_LO)));
                           o.contact_height = Q16_W'(ch);
                           o.altitude = Q16_W'(ch + over);
                           if ($urandom_range(0, 1))
                              {o.altitude, o.contact_height} = {o.contact_height, o.altitude};
                        end
                     endcase
                  end
                  send_observation(o);
                  sent++;
               end
            end
         end
      end
   endtask

   // Hold off the result channel: random bursts, or one long hold on request
   initial begin : rsp_backpressure
      int burst;
      forever begin
         @(posedge clock);
         burst = 0;
         if (hold_rsp_cycles != 0) begin
            burst = hold_rsp_cycles;
            hold_rsp_cycles = 0;
         end else if (stall_rsp_en && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 13);
         end
         if (burst != 0) begin
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each accepted result beat with the oldest expectation
   always @(posedge clock) begin : check_results
      logic want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         results_seen++;
         if (expected_stable.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result beat %0d with nothing expected: landed_stable=%0b",
                        results_seen, rsp_landed_stable);
         end else begin
            want = expected_stable.pop_front();
            if (rsp_landed_stable !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result beat %0d landed_stable: expected %0b, got %0b",
                           results_seen, want, rsp_landed_stable);
            end
         end
      end
   end

   // Watchdog: end the run after too many cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && !rsp_stall) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", quiet_cycles);
         $display("[landing_stability_qualifier] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : run_tests
      cfg = cfg_type'{STABLE_TIME_RST, MAX_SPEED_RST, HEIGHT_TOL_RST, MIN_SAMPLES_RST};
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_register_extremes();
      test_backpressure();
      test_random_runs();
      drain_results(DRAIN_CYCLES);
      if (mismatches == 0 && expected_stable.size() == 0) begin
         $display("[landing_stability_qualifier] OK");
      end else begin
         $display("[landing_stability_qualifier] ERROR");
      end
      $finish;
   end

endmodule
